// ===== design/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the sorted list engine: store size, widths,
// operation and status codes, and the request record between front and back.
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int KIND_W   = 2;
	localparam int STAT_W   = 2;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = 1;
	localparam int QCNT_W   = 2;

	typedef enum logic [KIND_W-1:0] {
		OP_INSERT  = 2'd0,
		OP_DEL_MIN = 2'd1,
		OP_DEL_MAX = 2'd2,
		OP_SEARCH  = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [VAL_W-1:0]  value;
	} req_t;

endpackage

// ===== design/sle_front.sv =====
// ----------------------------------------------------------------------------
// sle_front
// Request intake: decodes the operation and holds requests in a short queue
// until the back end takes them.
// ----------------------------------------------------------------------------
module sle_front
	import sle_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [KIND_W-1:0]    kind,
	input  logic [VAL_W-1:0]     value,
	output logic                 head_valid,
	output req_t                 head,
	input  logic                 pop
);

	req_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              push;
	logic              take;
	req_t              in_req;

	assign busy       = (fill_q == QCNT_W'(QDEPTH));
	assign push       = start && !busy;
	assign head_valid = (fill_q != '0);
	assign take       = pop && head_valid;
	assign head       = slot_q[rd_ptr_q];

	always_comb begin
		in_req.op    = op_t'(kind);
		in_req.value = value;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, take})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== design/sle_back.sv =====
// ----------------------------------------------------------------------------
// sle_back
// Execution: a row of compare-and-shift cells holding the ordered values,
// carrying out one request per cycle and registering its result.
// ----------------------------------------------------------------------------
module sle_back
	import sle_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  req_t                 head,
	output logic                 pop,
	output logic                 done,
	output logic [STAT_W-1:0]    status,
	output logic [VAL_W-1:0]     removed_value,
	output logic [CNT_W-1:0]     position,
	output logic [CNT_W-1:0]     entry_count
);

	logic signed [VAL_W-1:0] ent_q [CAPACITY];
	logic signed [VAL_W-1:0] ent_d [CAPACITY];
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_d;
	logic                    done_q;
	status_t                 status_q;
	logic [VAL_W-1:0]        removed_q;
	logic [CNT_W-1:0]        pos_q;

	logic [CAPACITY-1:0]     lt;
	logic [CAPACITY-1:0]     eq;
	logic signed [VAL_W-1:0] key;
	logic                    empty;
	logic                    full;
	logic [CNT_W-1:0]        last;
	logic [CNT_W-1:0]        found;
	status_t                 status_d;
	logic [VAL_W-1:0]        removed_d;
	logic [CNT_W-1:0]        pos_d;

	assign pop   = head_valid;
	assign key   = $signed(head.value);
	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(CAPACITY));
	assign last  = count_q - 1'b1;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			lt[i] = (CNT_W'(i) < count_q) && (ent_q[i] < key);
			eq[i] = (CNT_W'(i) < count_q) && (ent_q[i] == key);
		end
		found = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (eq[i]) begin
				found = CNT_W'(i + 1);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			ent_d[i] = ent_q[i];
		end
		count_d   = count_q;
		status_d  = ST_DONE;
		removed_d = '0;
		pos_d     = '0;
		case (head.op)
			OP_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					if (!lt[0]) begin
						ent_d[0] = key;
					end
					for (int i = 1; i < CAPACITY; i++) begin
						if (!lt[i]) begin
							ent_d[i] = lt[i-1] ? key : ent_q[i-1];
						end
					end
					count_d = count_q + 1'b1;
				end
			end
			OP_DEL_MIN: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					removed_d = ent_q[0];
					for (int i = 0; i < CAPACITY - 1; i++) begin
						ent_d[i] = ent_q[i+1];
					end
					count_d = count_q - 1'b1;
				end
			end
			OP_DEL_MAX: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					removed_d = ent_q[last[IDX_W-1:0]];
					count_d   = count_q - 1'b1;
				end
			end
			OP_SEARCH: begin
				pos_d = found;
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_valid) begin
			for (int i = 0; i < CAPACITY; i++) begin
				ent_q[i] <= ent_d[i];
			end
			status_q  <= status_d;
			removed_q <= removed_d;
			pos_q     <= pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= head_valid;
			if (head_valid) begin
				count_q <= count_d;
			end
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign position      = pos_q;
	assign entry_count   = count_q;

endmodule

// ===== design/sorted_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_list_engine_unit
// Ordered store of signed values with insert, delete smallest, delete largest
// and search, one result per request.
//
//   channel   handshake           fields
//   request   start / busy        kind, value
//   result    done (one cycle)    status, removed_value, position, entry_count
//
// The result strobe rises at the edge after acceptance, and one request per cycle
// is sustained. Reset clears the count and the queue; stored values are undefined
// until written. busy rises only when the two-entry request queue is full.
// ----------------------------------------------------------------------------
module sorted_list_engine_unit
	import sle_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [KIND_W-1:0]    kind,
	input  logic [VAL_W-1:0]     value,
	output logic                 done,
	output logic [STAT_W-1:0]    status,
	output logic [VAL_W-1:0]     removed_value,
	output logic [CNT_W-1:0]     position,
	output logic [CNT_W-1:0]     entry_count
);

	logic head_valid;
	req_t head;
	logic pop;

	sle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.value      (value),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	sle_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.done          (done),
		.status        (status),
		.removed_value (removed_value),
		.position      (position),
		.entry_count   (entry_count)
	);

endmodule

// ===== tb/tb_sorted_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_list_engine_unit
// Self-checking bench for the sorted list engine. Requests go in on the
// start/busy handshake with random gaps. A local model of the ordered store
// predicts each result when its request is accepted. Every done strobe is
// then compared field by field with the oldest prediction. Directed tests
// cover the empty store, extreme and equal values, and the full store. A long
// random mix then follows, with phases that vary the insert/delete balance.
// ----------------------------------------------------------------------------
module tb_sorted_list_engine_unit;
	import sle_pkg::*;

	typedef struct {
		status_t             st;
		logic [VAL_W-1:0]    removed;
		logic [CNT_W-1:0]    pos;
		logic [CNT_W-1:0]    cnt;
	} list_outcome_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [KIND_W-1:0]    kind;
	logic [VAL_W-1:0]     value;
	logic                 done;
	logic [STAT_W-1:0]    status;
	logic [VAL_W-1:0]     removed_value;
	logic [CNT_W-1:0]     position;
	logic [CNT_W-1:0]     entry_count;

	logic signed [VAL_W-1:0] sorted_vals [CAPACITY];
	int                      stored_cnt = 0;
	list_outcome_t           queued_outcomes [$];
	bit                      no_idle = 1'b0;

	int n_accepted = 0;
	int n_checked  = 0;
	int n_errors   = 0;
	int n_full     = 0;
	int n_empty    = 0;
	int n_hits     = 0;

	sorted_list_engine_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.value         (value),
		.done          (done),
		.status        (status),
		.removed_value (removed_value),
		.position      (position),
		.entry_count   (entry_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic list_outcome_t step_sorted_list(op_t op, logic signed [VAL_W-1:0] v);
		list_outcome_t o;
		int            at;
		o.st      = ST_DONE;
		o.removed = '0;
		o.pos     = '0;
		case (op)
			OP_INSERT: begin
				if (stored_cnt >= CAPACITY) begin
					o.st = ST_FULL;
					n_full++;
				end else begin
					at = stored_cnt;
					for (int i = 0; i < stored_cnt; i++)
						if (sorted_vals[i] >= v) begin
							at = i;
							break;
						end
					for (int i = stored_cnt; i > at; i--)
						sorted_vals[i] = sorted_vals[i-1];
					sorted_vals[at] = v;
					stored_cnt++;
				end
			end
			OP_DEL_MIN: begin
				if (stored_cnt == 0) begin
					o.st = ST_EMPTY;
					n_empty++;
				end else begin
					o.removed = sorted_vals[0];
					for (int i = 1; i < stored_cnt; i++)
						sorted_vals[i-1] = sorted_vals[i];
					stored_cnt--;
				end
			end
			OP_DEL_MAX: begin
				if (stored_cnt == 0) begin
					o.st = ST_EMPTY;
					n_empty++;
				end else begin
					o.removed = sorted_vals[stored_cnt-1];
					stored_cnt--;
				end
			end
			default: begin
				for (int i = 0; i < stored_cnt; i++)
					if (sorted_vals[i] == v) begin
						o.pos = CNT_W'(i + 1);
						n_hits++;
						break;
					end
			end
		endcase
		o.cnt = CNT_W'(stored_cnt);
		return o;
	endfunction

	// compare each result before taking in the request of the same edge
	always @(posedge clk) begin : result_check
		list_outcome_t exp_o;
		if (arst_n) begin
			if (done) begin
				if (queued_outcomes.size() == 0) begin
					n_errors++;
					$error("result with no request outstanding");
				end else begin
					exp_o = queued_outcomes.pop_front();
					n_checked++;
					if (status !== exp_o.st) begin
						n_errors++;
						$error("status: expected %0d, got %0d", exp_o.st, status);
					end
					if (removed_value !== exp_o.removed) begin
						n_errors++;
						$error("removed_value: expected %0d, got %0d",
							$signed(exp_o.removed), $signed(removed_value));
					end
					if (position !== exp_o.pos) begin
						n_errors++;
						$error("position: expected %0d, got %0d", exp_o.pos, position);
					end
					if (entry_count !== exp_o.cnt) begin
						n_errors++;
						$error("entry_count: expected %0d, got %0d", exp_o.cnt, entry_count);
					end
				end
			end
			if (start && !busy) begin
				queued_outcomes.push_back(step_sorted_list(op_t'(kind), value));
				n_accepted++;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 8);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		int r;
		int s;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			s = $urandom_range(0, 16);
			return VAL_W'(s - 8);
		end
		if (r < 50) begin
			case ($urandom_range(0, 5))
				0: return 32'h8000_0000;
				1: return 32'h8000_0001;
				2: return 32'h7FFF_FFFF;
				3: return 32'h7FFF_FFFE;
				4: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		if (r < 65 && stored_cnt > 0)
			return sorted_vals[$urandom_range(0, stored_cnt - 1)];
		return $urandom;
	endfunction

	function automatic logic [VAL_W-1:0] pick_key();
		if (stored_cnt > 0 && $urandom_range(0, 99) < 60)
			return sorted_vals[$urandom_range(0, stored_cnt - 1)];
		return pick_value();
	endfunction

	// hold the request until taken, then idle for a random gap
	task automatic send_request(input op_t op, input logic [VAL_W-1:0] val);
		int gap;
		start <= 1'b1;
		kind  <= op;
		value <= val;
		do @(posedge clk); while (busy);
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(negedge clk);
		while (queued_outcomes.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_empty_store();
		send_request(OP_DEL_MIN, $urandom);
		send_request(OP_DEL_MAX, $urandom);
		send_request(OP_SEARCH, 32'h0);
		send_request(OP_SEARCH, $urandom);
	endtask

	task automatic test_extreme_values();
		send_request(OP_INSERT, 32'h7FFF_FFFF);
		send_request(OP_INSERT, 32'h8000_0000);
		send_request(OP_INSERT, 32'h0000_0000);
		send_request(OP_INSERT, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 32'h0000_0001);
		send_request(OP_SEARCH, 32'h7FFF_FFFF);
		send_request(OP_SEARCH, 32'h8000_0000);
		send_request(OP_SEARCH, 32'h0000_0002);
	endtask

	task automatic test_equal_values();
		send_request(OP_INSERT, 32'h0000_0000);
		send_request(OP_INSERT, 32'hFFFF_FFFF);
		send_request(OP_SEARCH, 32'h0000_0000);
		send_request(OP_SEARCH, 32'hFFFF_FFFF);
		send_request(OP_DEL_MIN, $urandom);
		send_request(OP_DEL_MAX, $urandom);
	endtask

	task automatic test_full_store();
		while (stored_cnt < CAPACITY)
			send_request(OP_INSERT, pick_value());
		repeat (3) send_request(OP_INSERT, pick_value());
		send_request(OP_SEARCH, sorted_vals[CAPACITY-1]);
		send_request(OP_SEARCH, pick_key());
		wait_drained();
		while (stored_cnt > 0)
			send_request($urandom_range(0, 1) ? OP_DEL_MIN : OP_DEL_MAX, $urandom);
		send_request(OP_DEL_MAX, $urandom);
		send_request(OP_DEL_MIN, $urandom);
	endtask

	task automatic test_random_mix(input int n_items);
		int sent;
		int phase_len;
		int ins_weight;
		int r;
		sent = 0;
		while (sent < n_items) begin
			phase_len  = $urandom_range(30, 80);
			ins_weight = $urandom_range(15, 85);
			no_idle    = ($urandom_range(0, 4) == 0);
			repeat (phase_len) begin
				r = $urandom_range(0, 99);
				if (r < ins_weight)
					send_request(OP_INSERT, pick_value());
				else
					case ($urandom_range(0, 2))
						0: send_request(OP_DEL_MIN, $urandom);
						1: send_request(OP_DEL_MAX, $urandom);
						default: send_request(OP_SEARCH, pick_key());
					endcase
				sent++;
			end
			if ($urandom_range(0, 7) == 0)
				wait_drained();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		kind   = OP_INSERT;
		value  = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_store();
		test_extreme_values();
		test_equal_values();
		test_full_store();
		test_random_mix(1200);
		wait_drained();
		repeat (10) @(negedge clk);
		$display("Covered %0d requests and %0d results checked across all four operations.",
			n_accepted, n_checked);
		$display("Full-store rejects %0d, deletes on empty %0d, search hits %0d.",
			n_full, n_empty, n_hits);
		if (n_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#500000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
